// File: rtl/fbdrt_pkg.sv
// fbdrt_pkg: shared types, command and status codes, default screen geometry
// for the framebuffer dirty rectangle tracker. No dependencies.
`default_nettype none

package fbdrt_pkg;

	// default screen geometry
	localparam int DEF_SCREEN_WIDTH    = 320;
	localparam int DEF_SCREEN_HEIGHT   = 240;
	localparam int DEF_BYTES_PER_PIXEL = 3;

	// command codes
	localparam logic [1:0] ACT_MARK  = 2'd0;
	localparam logic [1:0] ACT_GET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_FLUSH = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BOUNDS    = 2'd1;
	localparam logic [1:0] ST_NOT_MEM   = 2'd2;
	localparam logic [1:0] ST_INVISIBLE = 2'd3;

	// display modes, only the memory-backed one allows mark and flush
	localparam logic [1:0] MODE_TEXT     = 2'd0;
	localparam logic [1:0] MODE_DIRECT   = 2'd1;
	localparam logic [1:0] MODE_MEMORY   = 2'd2;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	typedef struct packed {
		logic [15:0] h;
		logic [15:0] w;
		logic [15:0] y;
		logic [15:0] x;
	} rect_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [17:0] start_addr;
		logic [7:0]  h;
		logic [8:0]  w;
		logic [7:0]  y;
		logic [8:0]  x;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/fbdrt_box.sv
// fbdrt_box: dirty box state and the single-pass command evaluation.
// Depends on fbdrt_pkg.
`default_nettype none

module fbdrt_box #(
	parameter int SCREEN_WIDTH    = fbdrt_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT   = fbdrt_pkg::DEF_SCREEN_HEIGHT,
	parameter int BYTES_PER_PIXEL = fbdrt_pkg::DEF_BYTES_PER_PIXEL
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fire,
	input  wire [1:0]            mode,
	input  wire [1:0]            act,
	input  fbdrt_pkg::rect_t     rect,
	output fbdrt_pkg::res_t      res
);

	localparam int XW = $clog2(SCREEN_WIDTH + 1);
	localparam int YW = $clog2(SCREEN_HEIGHT + 1);
	localparam int ROW_BYTES = SCREEN_WIDTH * BYTES_PER_PIXEL;

	logic          box_valid_q;
	logic [XW-1:0] box_x_q, box_w_q;
	logic [YW-1:0] box_y_q, box_h_q;

	logic          nxt_valid;
	logic [XW-1:0] nxt_x, nxt_w;
	logic [YW-1:0] nxt_y, nxt_h;

	logic [16:0] rx, ry, rw, rh;
	logic [16:0] bx, by, bw, bh;
	logic [16:0] left, top, right, bottom;
	logic [16:0] sx, sy, sw, sh, cw, ch;
	logic        mem_mode, empty, in_bounds, off_screen;
	logic [31:0] ox, oy, ow, oh, oa;
	logic [1:0]  st;

	always_comb begin
		rx = {1'b0, rect.x};
		ry = {1'b0, rect.y};
		rw = {1'b0, rect.w};
		rh = {1'b0, rect.h};
		bx = 17'(box_x_q);
		by = 17'(box_y_q);
		bw = 17'(box_w_q);
		bh = 17'(box_h_q);
		mem_mode = (mode == fbdrt_pkg::MODE_MEMORY);
		empty = (rect.w == 16'd0) || (rect.h == 16'd0);
		in_bounds = (rx < 17'(SCREEN_WIDTH)) && (ry < 17'(SCREEN_HEIGHT)) &&
			(rx + rw <= 17'(SCREEN_WIDTH)) && (ry + rh <= 17'(SCREEN_HEIGHT));

		// union of the marked rectangle and the current box
		left   = (rx < bx) ? rx : bx;
		top    = (ry < by) ? ry : by;
		right  = (rx + rw > bx + bw) ? rx + rw : bx + bw;
		bottom = (ry + rh > by + bh) ? ry + rh : by + bh;

		// flush picks the given rect, else the box, else the full screen
		if (!empty) begin
			sx = rx; sy = ry; sw = rw; sh = rh;
		end else if (box_valid_q) begin
			sx = bx; sy = by; sw = bw; sh = bh;
		end else begin
			sx = 17'd0; sy = 17'd0;
			sw = 17'(SCREEN_WIDTH); sh = 17'(SCREEN_HEIGHT);
		end
		off_screen = (sw == 17'd0) || (sh == 17'd0) ||
			(sx >= 17'(SCREEN_WIDTH)) || (sy >= 17'(SCREEN_HEIGHT));
		cw = (sx + sw > 17'(SCREEN_WIDTH)) ? 17'(SCREEN_WIDTH) - sx : sw;
		ch = (sy + sh > 17'(SCREEN_HEIGHT)) ? 17'(SCREEN_HEIGHT) - sy : sh;

		nxt_valid = box_valid_q;
		nxt_x = box_x_q;
		nxt_y = box_y_q;
		nxt_w = box_w_q;
		nxt_h = box_h_q;
		st = fbdrt_pkg::ST_OK;
		ox = 32'd0;
		oy = 32'd0;
		ow = 32'd0;
		oh = 32'd0;
		oa = 32'd0;

		case (act)
			fbdrt_pkg::ACT_MARK: begin
				if (!mem_mode) begin
					st = fbdrt_pkg::ST_NOT_MEM;
				end else if (empty) begin
					st = fbdrt_pkg::ST_OK;
				end else if (!in_bounds) begin
					st = fbdrt_pkg::ST_BOUNDS;
				end else if (!box_valid_q) begin
					nxt_valid = 1'b1;
					nxt_x = rx[XW-1:0];
					nxt_y = ry[YW-1:0];
					nxt_w = rw[XW-1:0];
					nxt_h = rh[YW-1:0];
				end else begin
					nxt_x = left[XW-1:0];
					nxt_y = top[YW-1:0];
					nxt_w = XW'(right - left);
					nxt_h = YW'(bottom - top);
				end
			end
			fbdrt_pkg::ACT_GET: begin
				if (box_valid_q) begin
					ox = 32'(box_x_q);
					oy = 32'(box_y_q);
					ow = 32'(box_w_q);
					oh = 32'(box_h_q);
				end
			end
			fbdrt_pkg::ACT_CLEAR: begin
				nxt_valid = 1'b0;
				nxt_x = '0;
				nxt_y = '0;
				nxt_w = '0;
				nxt_h = '0;
			end
			fbdrt_pkg::ACT_FLUSH: begin
				if (!mem_mode) begin
					st = fbdrt_pkg::ST_NOT_MEM;
				end else if (off_screen) begin
					st = fbdrt_pkg::ST_INVISIBLE;
				end else begin
					ox = 32'(sx);
					oy = 32'(sy);
					ow = 32'(cw);
					oh = 32'(ch);
					oa = 32'(sy) * 32'(ROW_BYTES) + 32'(sx) * 32'(BYTES_PER_PIXEL);
				end
			end
			default: begin
				st = fbdrt_pkg::ST_OK;
			end
		endcase

		res.status     = st;
		res.x          = ox[8:0];
		res.y          = oy[7:0];
		res.w          = ow[8:0];
		res.h          = oh[7:0];
		res.start_addr = oa[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= 1'b0;
			box_x_q <= '0;
			box_y_q <= '0;
			box_w_q <= '0;
			box_h_q <= '0;
		end else if (fire) begin
			box_valid_q <= nxt_valid;
			box_x_q <= nxt_x;
			box_y_q <= nxt_y;
			box_w_q <= nxt_w;
			box_h_q <= nxt_h;
		end
	end

endmodule

`default_nettype wire

// File: rtl/framebuffer_dirty_rect_tracker.sv
// framebuffer_dirty_rect_tracker: top level with input register, result
// register and display mode register. Depends on fbdrt_pkg and fbdrt_box.
//
// Keeps one bounding box around every rectangle marked since the last clear
// and answers mark, get, clear and flush commands, one result per command.
// A command is taken on every cycle in which the input register is empty or
// its command moves on to the result register at the same edge. A result is
// offered once its command has been evaluated out of the input register into
// the result register, and transfers when the receiver takes it. Throughput
// is one command per clock while the receiver takes results, set by the single
// evaluation pass between the two registers, which also updates the box; while
// the receiver holds off, up to two commands wait inside. The display mode may
// only be written while no command is in flight.
`default_nettype none

module framebuffer_dirty_rect_tracker #(
	parameter int SCREEN_WIDTH    = fbdrt_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT   = fbdrt_pkg::DEF_SCREEN_HEIGHT,
	parameter int BYTES_PER_PIXEL = fbdrt_pkg::DEF_BYTES_PER_PIXEL
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_data,   // display_mode
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,    // rect_x, rect_y, rect_w, rect_h
	input  wire  [1:0]  s_tuser,    // action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,    // out_x, out_y, out_w, out_h, start_addr, zero pad
	output logic [1:0]  m_tuser     // status
);

	logic [1:0]        mode_q;
	logic              valid_s1;
	logic [1:0]        act_s1;
	fbdrt_pkg::rect_t  rect_s1;
	logic              valid_s2;
	fbdrt_pkg::res_t   res_s2;
	fbdrt_pkg::res_t   res;
	logic              out_free, advance;

	assign cfg_ready = 1'b1;
	assign out_free  = !valid_s2 || m_tready;
	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fbdrt_pkg::MODE_TEXT;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= s_tuser;
			rect_s1 <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	fbdrt_box #(
		.SCREEN_WIDTH   (SCREEN_WIDTH),
		.SCREEN_HEIGHT  (SCREEN_HEIGHT),
		.BYTES_PER_PIXEL(BYTES_PER_PIXEL)
	) u_box (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.mode  (mode_q),
		.act   (act_s1),
		.rect  (rect_s1),
		.res   (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = {4'd0, res_s2.start_addr, res_s2.h, res_s2.w, res_s2.y, res_s2.x};

endmodule

`default_nettype wire

// File: rtl/fbdrt_chk.sv
// fbdrt_chk: port-level checks for framebuffer_dirty_rect_tracker, bound to
// the top level. Depends on fbdrt_pkg.
`default_nettype none

module fbdrt_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [55:0] m_tdata,
	input wire [1:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// error results carry no rectangle
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != fbdrt_pkg::ST_OK |-> m_tdata == 56'd0)
		else $error("error result with nonzero fields");

	// a zero-width result is the all-zero rectangle
	a_empty_rect: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25:17] == 9'd0 |-> m_tdata[33:26] == 8'd0 &&
			m_tdata[16:0] == 17'd0 && m_tdata[51:34] == 18'd0)
		else $error("empty rectangle with nonzero fields");

	// padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:52] == 4'd0)
		else $error("pad bits set");

endmodule

bind framebuffer_dirty_rect_tracker fbdrt_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

// File: tb/framebuffer_dirty_rect_tracker_test.sv
// framebuffer_dirty_rect_tracker_test: self-checking bench for the dirty rectangle tracker.
// Needs fbdrt_pkg and the tracker RTL. It predicts every result itself and compares
// each one, field by field, as it comes out of the result stream.
`default_nettype none

module framebuffer_dirty_rect_tracker_test;

	localparam int SW  = fbdrt_pkg::DEF_SCREEN_WIDTH;
	localparam int SH  = fbdrt_pkg::DEF_SCREEN_HEIGHT;
	localparam int BPP = fbdrt_pkg::DEF_BYTES_PER_PIXEL;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;   // rect_x, rect_y, rect_w, rect_h
	logic [1:0]  s_tuser   = '0;   // action
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;          // out_x, out_y, out_w, out_h, start_addr, zero pad
	logic [1:0]  m_tuser;          // status

	// shadow of the tracker's register and box
	logic [1:0] mode_shadow = fbdrt_pkg::MODE_TEXT;
	bit         box_ok      = 1'b0;
	logic [8:0] box_x       = '0;
	logic [7:0] box_y       = '0;
	logic [8:0] box_w       = '0;
	logic [7:0] box_h       = '0;

	fbdrt_pkg::res_t pending_results[$];
	int   errors         = 0;
	bit   src_idle_en    = 1'b1;
	bit   sink_idle_en   = 1'b1;
	int   sink_hold_req  = 0;
	int   sink_hold_left = 0;

	framebuffer_dirty_rect_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// applies one command to the shadow box and returns the result it gives
	function automatic fbdrt_pkg::res_t track_command(logic [1:0] act, logic [15:0] rx,
			logic [15:0] ry, logic [15:0] rw, logic [15:0] rh);
		fbdrt_pkg::res_t r;
		int   fx, fy, fw, fh;
		r  = '0;
		fx = int'(rx);
		fy = int'(ry);
		fw = int'(rw);
		fh = int'(rh);
		case (act)
			fbdrt_pkg::ACT_MARK: begin
				if (mode_shadow != fbdrt_pkg::MODE_MEMORY) begin
					r.status = fbdrt_pkg::ST_NOT_MEM;
				end else if (fw == 0 || fh == 0) begin
					r.status = fbdrt_pkg::ST_OK;
				end else if (fx >= SW || fy >= SH || fx + fw > SW || fy + fh > SH) begin
					r.status = fbdrt_pkg::ST_BOUNDS;
				end else if (!box_ok) begin
					box_x  = 9'(fx);
					box_y  = 8'(fy);
					box_w  = 9'(fw);
					box_h  = 8'(fh);
					box_ok = 1'b1;
				end else begin
					// left and top edges move first, then the far edges are measured
					if (fx < int'(box_x)) begin
						box_w = 9'(int'(box_w) + int'(box_x) - fx);
						box_x = 9'(fx);
					end
					if (fy < int'(box_y)) begin
						box_h = 8'(int'(box_h) + int'(box_y) - fy);
						box_y = 8'(fy);
					end
					if (fx + fw > int'(box_x) + int'(box_w))
						box_w = 9'(fx + fw - int'(box_x));
					if (fy + fh > int'(box_y) + int'(box_h))
						box_h = 8'(fy + fh - int'(box_y));
				end
			end
			fbdrt_pkg::ACT_GET: begin
				if (box_ok) begin
					r.x = box_x;
					r.y = box_y;
					r.w = box_w;
					r.h = box_h;
				end
			end
			fbdrt_pkg::ACT_CLEAR: begin
				box_ok = 1'b0;
				box_x  = '0;
				box_y  = '0;
				box_w  = '0;
				box_h  = '0;
			end
			fbdrt_pkg::ACT_FLUSH: begin
				if (mode_shadow != fbdrt_pkg::MODE_MEMORY) begin
					r.status = fbdrt_pkg::ST_NOT_MEM;
				end else begin
					// empty request falls back to the dirty box, then to the whole screen
					if (fw == 0 || fh == 0) begin
						if (box_ok) begin
							fx = int'(box_x);
							fy = int'(box_y);
							fw = int'(box_w);
							fh = int'(box_h);
						end else begin
							fx = 0;
							fy = 0;
							fw = SW;
							fh = SH;
						end
					end
					if (fw == 0 || fh == 0 || fx >= SW || fy >= SH) begin
						r.status = fbdrt_pkg::ST_INVISIBLE;
					end else begin
						if (fx + fw > SW)
							fw = SW - fx;
						if (fy + fh > SH)
							fh = SH - fy;
						r.x          = 9'(fx);
						r.y          = 8'(fy);
						r.w          = 9'(fw);
						r.h          = 8'(fh);
						r.start_addr = 18'(fy * SW * BPP + fx * BPP);
					end
				end
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// result side: random backpressure, a counted long hold-off, and the compare
	always @(posedge clk) begin
		fbdrt_pkg::res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no command outstanding");
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", int'(want.status), int'(m_tuser));
					check_field("out_x", int'(want.x), int'(m_tdata[8:0]));
					check_field("out_y", int'(want.y), int'(m_tdata[16:9]));
					check_field("out_w", int'(want.w), int'(m_tdata[25:17]));
					check_field("out_h", int'(want.h), int'(m_tdata[33:26]));
					check_field("start_addr", int'(want.start_addr), int'(m_tdata[51:34]));
				end
			end
			if (sink_hold_req > 0) begin
				sink_hold_left = sink_hold_req;
				sink_hold_req  = 0;
			end
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(sink_idle_en && $urandom_range(99) < 38);
			end
		end
	end

	task automatic send_cmd(logic [1:0] act, logic [15:0] rx, logic [15:0] ry,
			logic [15:0] rw, logic [15:0] rh);
		int gap;
		gap = 0;
		if (src_idle_en)
			while ($urandom_range(99) < 38)
				gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {rh, rw, ry, rx};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(track_command(act, rx, ry, rw, rh));
	endtask

	// stop offering commands and wait for every outstanding result
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		mode_shadow  = m;
	endtask

	function automatic logic [15:0] boundary_value(int lim);
		case ($urandom_range(6))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'(lim - 1);
			3: return 16'(lim);
			4: return 16'(lim + 1);
			5: return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic send_random_command;
		logic [1:0]  act;
		logic [15:0] rx, ry, rw, rh;
		int          pick, room;
		pick = int'($urandom_range(99));
		act  = pick < 45 ? fbdrt_pkg::ACT_MARK : pick < 63 ? fbdrt_pkg::ACT_GET
			: pick < 70 ? fbdrt_pkg::ACT_CLEAR : fbdrt_pkg::ACT_FLUSH;
		pick = int'($urandom_range(99));
		if (pick < 70) begin
			// on-screen rectangle, mostly small
			rx   = 16'($urandom_range(SW - 1));
			ry   = 16'($urandom_range(SH - 1));
			room = SW - int'(rx);
			rw   = 16'($urandom_range(99) < 80 ? $urandom_range(1, room < 40 ? room : 40)
				: $urandom_range(1, room));
			room = SH - int'(ry);
			rh   = 16'($urandom_range(99) < 80 ? $urandom_range(1, room < 40 ? room : 40)
				: $urandom_range(1, room));
			if (act == fbdrt_pkg::ACT_FLUSH && $urandom_range(99) < 30) begin
				rw = 16'($urandom_range(1, 2 * SW));
				rh = 16'($urandom_range(1, 2 * SH));
			end
		end else if (pick < 85) begin
			rx = boundary_value(SW);
			ry = boundary_value(SH);
			rw = boundary_value(SW);
			rh = boundary_value(SH);
		end else begin
			rx = 16'($urandom);
			ry = 16'($urandom);
			rw = 16'($urandom);
			rh = 16'($urandom);
		end
		if (act == fbdrt_pkg::ACT_FLUSH && $urandom_range(99) < 40) begin
			if ($urandom_range(1))
				rw = '0;
			else
				rh = '0;
		end
		send_cmd(act, rx, ry, rw, rh);
	endtask

	task automatic test_after_reset;
		send_cmd(fbdrt_pkg::ACT_GET, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd10, 16'd10, 16'd5, 16'd5);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(fbdrt_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0);
	endtask

	task automatic test_mode_gating;
		write_mode(fbdrt_pkg::MODE_DIRECT);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd1, 16'd2, 16'd3, 16'd4);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd1, 16'd2, 16'd3, 16'd4);
		write_mode(fbdrt_pkg::MODE_RESERVED);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd1, 16'd2, 16'd3, 16'd4);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(fbdrt_pkg::ACT_GET, 16'd0, 16'd0, 16'd0, 16'd0);
	endtask

	task automatic test_mark_cases;
		write_mode(fbdrt_pkg::MODE_MEMORY);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd5, 16'd5, 16'd0, 16'd7);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd5, 16'd5, 16'd7, 16'd0);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'(SW), 16'd0, 16'd1, 16'd1);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd0, 16'(SH), 16'd1, 16'd1);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd300, 16'd0, 16'd21, 16'd1);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd0, 16'd200, 16'd1, 16'd41);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'(SW - 1), 16'(SH - 1), 16'd1, 16'd1);
		send_cmd(fbdrt_pkg::ACT_GET, 16'd0, 16'd0, 16'd0, 16'd0);
		// grows left and up while the far corner stays
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd10, 16'd20, 16'd5, 16'd5);
		send_cmd(fbdrt_pkg::ACT_GET, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(fbdrt_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(fbdrt_pkg::ACT_GET, 16'd0, 16'd0, 16'd0, 16'd0);
	endtask

	task automatic test_flush_cases;
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(fbdrt_pkg::ACT_MARK, 16'd100, 16'd50, 16'd30, 16'd20);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd0, 16'd0, 16'd0, 16'd5);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd300, 16'd230, 16'd100, 16'd100);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'(SW), 16'd0, 16'd1, 16'd1);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd0, 16'hFFFF, 16'd1, 16'd1);
		send_cmd(fbdrt_pkg::ACT_FLUSH, 16'd0, 16'd0, 16'(SW), 16'(SH));
	endtask

	task automatic test_random_traffic;
		logic [1:0] phase_mode [8] = '{
			fbdrt_pkg::MODE_MEMORY, fbdrt_pkg::MODE_MEMORY, fbdrt_pkg::MODE_TEXT,
			fbdrt_pkg::MODE_MEMORY, fbdrt_pkg::MODE_DIRECT, fbdrt_pkg::MODE_MEMORY,
			fbdrt_pkg::MODE_RESERVED, fbdrt_pkg::MODE_MEMORY};
		for (int p = 0; p < 8; p++) begin
			write_mode(phase_mode[p]);
			src_idle_en  = (p != 0);
			sink_idle_en = (p != 0 && p != 5);
			// receiver holds off long enough for the tracker to back up
			if (p == 3)
				sink_hold_req = 300;
			for (int i = 0; i < 220; i++)
				send_random_command();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_mode_gating();
		test_mark_cases();
		test_flush_cases();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
